// ===== rtl/hccr_pkg.sv =====
// shared types, class codes and pixel classification for the hsv colour-class histogram
package hccr_pkg;

    localparam int COUNT_WIDTH     = 32;
    localparam int OUT_COUNT_WIDTH = 32;
    localparam int NUM_CLASSES     = 11;
    localparam int CLS_W           = 4;
    localparam int RANK_W          = 4;
    localparam int PIX_W           = 8;
    localparam int EXT_W           = (COUNT_WIDTH > OUT_COUNT_WIDTH) ? COUNT_WIDTH
                                                                     : OUT_COUNT_WIDTH;

    typedef logic [COUNT_WIDTH-1:0]     t_count;
    typedef logic [OUT_COUNT_WIDTH-1:0] t_out_count;
    typedef logic [CLS_W-1:0]           t_class;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_RANK  = 1'b1;

    localparam t_class CLS_BLACK  = 4'd0;
    localparam t_class CLS_GRAY   = 4'd1;
    localparam t_class CLS_WHITE  = 4'd2;
    localparam t_class CLS_RED    = 4'd3;
    localparam t_class CLS_ORANGE = 4'd4;
    localparam t_class CLS_YELLOW = 4'd5;
    localparam t_class CLS_GREEN  = 4'd6;
    localparam t_class CLS_CYAN   = 4'd7;
    localparam t_class CLS_BLUE   = 4'd8;
    localparam t_class CLS_PURPLE = 4'd9;
    localparam t_class CLS_OTHER  = 4'd10;

    localparam logic [PIX_W-1:0] HUE_MAX      = 8'd180;
    localparam logic [PIX_W-1:0] V_DARK       = 8'd46;
    localparam logic [PIX_W-1:0] S_GRAY       = 8'd43;
    localparam logic [PIX_W-1:0] V_GRAY_HI    = 8'd220;
    localparam logic [PIX_W-1:0] S_WHITE      = 8'd30;
    localparam logic [PIX_W-1:0] V_WHITE      = 8'd221;
    localparam logic [PIX_W-1:0] H_RED_LO     = 8'd10;
    localparam logic [PIX_W-1:0] H_RED_HI     = 8'd156;
    localparam logic [PIX_W-1:0] H_ORANGE_TOP = 8'd25;
    localparam logic [PIX_W-1:0] H_YELLOW_TOP = 8'd34;
    localparam logic [PIX_W-1:0] H_GREEN_TOP  = 8'd77;
    localparam logic [PIX_W-1:0] H_CYAN_TOP   = 8'd99;
    localparam logic [PIX_W-1:0] H_BLUE_TOP   = 8'd124;

    typedef struct packed {
        logic inc;
        logic rank_start;
        logic scan_step;
        logic emit;
        logic last;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_dp_stat;

    // first matching range wins
    function automatic t_class classify(input logic [PIX_W-1:0] h,
                                        input logic [PIX_W-1:0] s,
                                        input logic [PIX_W-1:0] v);
        logic   chroma;
        t_class c;
        chroma = (s >= S_GRAY) && (v >= V_DARK);
        if (h > HUE_MAX)                         c = CLS_OTHER;
        else if (v <= V_DARK)                    c = CLS_BLACK;
        else if (s <= S_GRAY && v <= V_GRAY_HI)  c = CLS_GRAY;
        else if (s <= S_WHITE && v >= V_WHITE)   c = CLS_WHITE;
        else if (!chroma)                        c = CLS_OTHER;
        else if (h <= H_RED_LO || h >= H_RED_HI) c = CLS_RED;
        else if (h <= H_ORANGE_TOP)              c = CLS_ORANGE;
        else if (h <= H_YELLOW_TOP)              c = CLS_YELLOW;
        else if (h <= H_GREEN_TOP)               c = CLS_GREEN;
        else if (h <= H_CYAN_TOP)                c = CLS_CYAN;
        else if (h <= H_BLUE_TOP)                c = CLS_BLUE;
        else                                     c = CLS_PURPLE;
        return c;
    endfunction

    // clamp a counter to the output field
    function automatic t_out_count sat_out(input t_count c);
        logic [EXT_W-1:0] e;
        e = EXT_W'(c);
        if (e > EXT_W'({OUT_COUNT_WIDTH{1'b1}})) begin
            return '1;
        end
        return e[OUT_COUNT_WIDTH-1:0];
    endfunction

endpackage

// ===== rtl/hsv_color_class_histogram_rank_top.sv =====
// top level of the hsv colour-class histogram with rank readout
// pixel items: one per cycle while no rank request stalls the input, counted in the cycle they are taken, no result
// rank items: one selection scan over the eleven counters plus one load of the output
//   register per result, repeated for each ranked class; a load waits while the output is stalled
// input stalls for the whole rank request; a pending result does not block new pixels
// synchronous active-low reset clears all counters and the control state
module hsv_color_class_histogram_rank_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_req_type,
    input  logic [hccr_pkg::PIX_W-1:0]         i_hue,
    input  logic [hccr_pkg::PIX_W-1:0]         i_saturation,
    input  logic [hccr_pkg::PIX_W-1:0]         i_brightness,
    input  logic [hccr_pkg::RANK_W-1:0]        i_rank_length,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output hccr_pkg::t_class                   o_class_code,
    output hccr_pkg::t_out_count               o_class_count,
    output logic                               o_last_rank
);

    hccr_pkg::t_dp_cmd  cmd;
    hccr_pkg::t_dp_stat stat;

    hccr_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_rank_length (i_rank_length),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    hccr_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_hue         (i_hue),
        .i_saturation  (i_saturation),
        .i_brightness  (i_brightness),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_class_code  (o_class_code),
        .o_class_count (o_class_count),
        .o_last_rank   (o_last_rank)
    );

endmodule

// ===== rtl/hccr_datapath.sv =====
// class counters, rank selection scan and output register
module hccr_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  hccr_pkg::t_dp_cmd                      i_cmd,
    output hccr_pkg::t_dp_stat                     o_stat,
    input  logic [hccr_pkg::PIX_W-1:0]             i_hue,
    input  logic [hccr_pkg::PIX_W-1:0]             i_saturation,
    input  logic [hccr_pkg::PIX_W-1:0]             i_brightness,
    input  logic                                   i_out_stall,
    output logic                                   o_out_valid,
    output hccr_pkg::t_class                       o_class_code,
    output hccr_pkg::t_out_count                   o_class_count,
    output logic                                   o_last_rank
);

    hccr_pkg::t_count                         r_cnt [hccr_pkg::NUM_CLASSES];
    logic [hccr_pkg::NUM_CLASSES-1:0]         r_done;
    hccr_pkg::t_class                         r_scan_idx;
    logic                                     r_found;
    hccr_pkg::t_class                         r_best_idx;
    hccr_pkg::t_count                         r_best_cnt;
    logic                                     r_out_valid;
    hccr_pkg::t_class                         r_out_code;
    hccr_pkg::t_out_count                     r_out_count;
    logic                                     r_out_last;

    hccr_pkg::t_class pix_class;
    hccr_pkg::t_count scan_cnt;
    logic             take;

    assign pix_class = hccr_pkg::classify(i_hue, i_saturation, i_brightness);
    assign scan_cnt  = r_cnt[r_scan_idx];
    // strict compare while scanning upwards keeps the lower code on ties
    assign take      = !r_done[r_scan_idx] && (!r_found || scan_cnt > r_best_cnt);

    assign o_stat.scan_last = (r_scan_idx == hccr_pkg::CLS_W'(hccr_pkg::NUM_CLASSES - 1));
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < hccr_pkg::NUM_CLASSES; k++) begin
                r_cnt[k] <= '0;
            end
            r_done      <= '0;
            r_scan_idx  <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            for (int k = 0; k < hccr_pkg::NUM_CLASSES; k++) begin
                if (i_cmd.inc && pix_class == hccr_pkg::CLS_W'(k) && r_cnt[k] != '1) begin
                    r_cnt[k] <= r_cnt[k] + hccr_pkg::COUNT_WIDTH'(1);
                end
            end
            if (i_cmd.rank_start) begin
                r_done     <= '0;
                r_scan_idx <= '0;
                r_found    <= 1'b0;
            end else if (i_cmd.scan_step) begin
                if (take) begin
                    r_found <= 1'b1;
                end
                if (!o_stat.scan_last) begin
                    r_scan_idx <= r_scan_idx + hccr_pkg::CLS_W'(1);
                end
            end else if (i_cmd.emit) begin
                r_done[r_best_idx] <= 1'b1;
                r_scan_idx         <= '0;
                r_found            <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && take) begin
            r_best_idx <= r_scan_idx;
            r_best_cnt <= scan_cnt;
        end
        if (i_cmd.emit) begin
            r_out_code  <= r_best_idx;
            r_out_count <= hccr_pkg::sat_out(r_best_cnt);
            r_out_last  <= i_cmd.last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_class_code  = r_out_code;
    assign o_class_count = r_out_count;
    assign o_last_rank   = r_out_last;

endmodule

// ===== rtl/hccr_ctrl.sv =====
// controller: input handshake and rank request sequencing
module hccr_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_req_type,
    input  logic [hccr_pkg::RANK_W-1:0]   i_rank_length,
    input  hccr_pkg::t_dp_stat            i_stat,
    output hccr_pkg::t_dp_cmd             o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]                  r_state, n_state;
    logic [hccr_pkg::RANK_W-1:0] r_remain, n_remain;
    logic [hccr_pkg::RANK_W-1:0] len_clamped;
    logic                        accept;

    assign o_in_stall  = (r_state != S_IDLE) || !i_rst_n;
    assign accept      = i_in_valid && !o_in_stall;
    assign len_clamped = (i_rank_length > hccr_pkg::RANK_W'(hccr_pkg::NUM_CLASSES))
                       ? hccr_pkg::RANK_W'(hccr_pkg::NUM_CLASSES) : i_rank_length;

    always_comb begin
        n_state  = r_state;
        n_remain = r_remain;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req_type == hccr_pkg::REQ_PIXEL) begin
                        o_cmd.inc = 1'b1;
                    end else if (len_clamped != '0) begin
                        o_cmd.rank_start = 1'b1;
                        n_remain         = len_clamped;
                        n_state          = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = (r_remain == hccr_pkg::RANK_W'(1));
                    n_remain   = r_remain - hccr_pkg::RANK_W'(1);
                    n_state    = (r_remain == hccr_pkg::RANK_W'(1)) ? S_IDLE : S_SCAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_remain <= '0;
        end else begin
            r_state  <= n_state;
            r_remain <= n_remain;
        end
    end

endmodule

// ===== rtl/hccr_checker.sv =====
// port-level checks for the histogram top level, bound to it
module hccr_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         i_req_type,
    input logic [hccr_pkg::RANK_W-1:0]  i_rank_length,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input hccr_pkg::t_class             o_class_code,
    input hccr_pkg::t_out_count         o_class_count,
    input logic                         o_last_rank
);

    logic acc;
    assign acc = i_in_valid && !o_in_stall;

    // a pixel never holds up the next item
    a_pixel_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_req_type == hccr_pkg::REQ_PIXEL |=> !o_in_stall)
        else $error("input stalled after a pixel item");

    // a non-empty rank request blocks input while it is scanned
    a_rank_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_req_type == hccr_pkg::REQ_RANK && i_rank_length != '0 |=> o_in_stall)
        else $error("rank request did not stall input");

    // an empty rank request gives nothing and frees the input at once
    a_empty_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_req_type == hccr_pkg::REQ_RANK && i_rank_length == '0 |=> !o_in_stall)
        else $error("empty rank request stalled input");

    // a ranked class code is always a real class
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_class_code <= hccr_pkg::CLS_OTHER)
        else $error("class code out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_class_code)
            && $stable(o_class_count) && $stable(o_last_rank))
        else $error("stalled result changed");

endmodule

bind hsv_color_class_histogram_rank_top hccr_checker u_hccr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_req_type    (i_req_type),
    .i_rank_length (i_rank_length),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_class_code  (o_class_code),
    .o_class_count (o_class_count),
    .o_last_rank   (o_last_rank)
);

// ===== test/colour_rank_checker.sv =====
// checker for the hsv colour-class histogram: keeps its own class tallies and checks rank readouts
module colour_rank_checker
    import hccr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic              i_req_type,
    input  logic [PIX_W-1:0]  i_hue,
    input  logic [PIX_W-1:0]  i_saturation,
    input  logic [PIX_W-1:0]  i_brightness,
    input  logic [RANK_W-1:0] i_rank_length,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  t_class            i_class_code,
    input  t_out_count        i_class_count,
    input  logic              i_last_rank,
    output int                o_fails,
    output int                o_owed
);

    typedef struct packed {
        t_class     code;
        t_out_count count;
        logic       last;
    } t_rank_entry;

    t_count      pixel_tally [NUM_CLASSES];
    t_rank_entry owed_ranks [$];

    function automatic t_class bin_of_pixel(input logic [PIX_W-1:0] h,
                                            input logic [PIX_W-1:0] s,
                                            input logic [PIX_W-1:0] v);
        if (h > 8'd180) return CLS_OTHER;
        if (v <= 8'd46) return CLS_BLACK;
        if (s <= 8'd43 && v <= 8'd220) return CLS_GRAY;
        if (s <= 8'd30 && v >= 8'd221) return CLS_WHITE;
        // brightness is above 46 here, so only a pale saturation leaves the colour bands
        if (s < 8'd43) return CLS_OTHER;
        if (h <= 8'd10 || h >= 8'd156) return CLS_RED;
        if (h <= 8'd25) return CLS_ORANGE;
        if (h <= 8'd34) return CLS_YELLOW;
        if (h <= 8'd77) return CLS_GREEN;
        if (h <= 8'd99) return CLS_CYAN;
        if (h <= 8'd124) return CLS_BLUE;
        return CLS_PURPLE;
    endfunction

    // largest tally first, lower code wins a tie
    task automatic queue_ranking(input logic [RANK_W-1:0] asked);
        bit          taken [NUM_CLASSES];
        int          n;
        int          pick;
        logic [63:0] wide;
        t_rank_entry e;
        n = (int'(asked) > NUM_CLASSES) ? NUM_CLASSES : int'(asked);
        foreach (taken[k]) taken[k] = 1'b0;
        for (int p = 0; p < n; p++) begin
            pick = -1;
            for (int k = 0; k < NUM_CLASSES; k++) begin
                if (!taken[k] && (pick < 0 || pixel_tally[k] > pixel_tally[pick])) begin
                    pick = k;
                end
            end
            taken[pick] = 1'b1;
            wide = 64'(pixel_tally[pick]);
            e.code  = t_class'(pick);
            e.count = (wide > 64'(t_out_count'('1))) ? '1 : t_out_count'(wide);
            e.last  = (p == n - 1);
            owed_ranks.push_back(e);
        end
    endtask

    task automatic note_miss(input string why, input t_rank_entry want, input t_rank_entry got);
        o_fails++;
        if (o_fails <= 10) begin
            $display("%s: expected code %0d count %0d last %0b, got code %0d count %0d last %0b",
                     why, want.code, want.count, want.last, got.code, got.count, got.last);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_rank_entry got;
        t_rank_entry want;
        t_class      c;
        if (!i_rst_n) begin
            foreach (pixel_tally[k]) pixel_tally[k] = '0;
            owed_ranks.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{i_class_code, i_class_count, i_last_rank};
                if (owed_ranks.size() == 0) begin
                    note_miss("unexpected rank item", '0, got);
                end else begin
                    want = owed_ranks.pop_front();
                    if (got !== want) note_miss("rank item differs", want, got);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_req_type == REQ_PIXEL) begin
                    c = bin_of_pixel(i_hue, i_saturation, i_brightness);
                    if (pixel_tally[c] != '1) pixel_tally[c] = pixel_tally[c] + t_count'(1);
                end else begin
                    queue_ranking(i_rank_length);
                end
            end
        end
        o_owed = owed_ranks.size();
    end

endmodule

// ===== test/hsv_color_class_histogram_rank_top_test.sv =====
// testbench top for the hsv colour-class histogram: drives pixels and rank requests
module hsv_color_class_histogram_rank_top_test;
    import hccr_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic              req_type;
    logic [PIX_W-1:0]  hue;
    logic [PIX_W-1:0]  saturation;
    logic [PIX_W-1:0]  brightness;
    logic [RANK_W-1:0] rank_length;
    logic              out_valid;
    logic              out_stall;
    t_class            class_code;
    t_out_count        class_count;
    logic              last_rank;

    int n_fails;
    int n_owed;
    bit calm;
    bit hold_req;

    hsv_color_class_histogram_rank_top DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_req_type    (req_type),
        .i_hue         (hue),
        .i_saturation  (saturation),
        .i_brightness  (brightness),
        .i_rank_length (rank_length),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_class_code  (class_code),
        .o_class_count (class_count),
        .o_last_rank   (last_rank)
    );

    colour_rank_checker tally_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_req_type    (req_type),
        .i_hue         (hue),
        .i_saturation  (saturation),
        .i_brightness  (brightness),
        .i_rank_length (rank_length),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_class_code  (class_code),
        .i_class_count (class_count),
        .i_last_rank   (last_rank),
        .o_fails       (n_fails),
        .o_owed        (n_owed)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // called just after a falling edge, returns just after the falling edge that follows acceptance
    task automatic offer(input logic rq, input logic [PIX_W-1:0] h, input logic [PIX_W-1:0] s,
                         input logic [PIX_W-1:0] v, input logic [RANK_W-1:0] len);
        while (!calm && $urandom_range(99) < 9) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid    = 1'b1;
        req_type    = rq;
        hue         = h;
        saturation  = s;
        brightness  = v;
        rank_length = len;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic random_pixel();
        if ($urandom_range(1)) begin
            offer(REQ_PIXEL, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 4'($urandom_range(15)));
        end else begin
            // mostly chromatic pixels spread over the colour bands
            offer(REQ_PIXEL, 8'($urandom_range(180)), 8'($urandom_range(255, 43)),
                  8'($urandom_range(255, 47)), 4'($urandom_range(15)));
        end
    endtask

    task automatic random_rank();
        logic [RANK_W-1:0] len;
        len = ($urandom_range(99) < 80) ? 4'($urandom_range(11, 1)) : 4'($urandom_range(15));
        offer(REQ_RANK, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), len);
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                out_stall = 1'b1;
                repeat (300) @(negedge clk);
            end
            out_stall = !calm && ($urandom_range(99) < 9);
        end
    end

    initial begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        req_type    = REQ_PIXEL;
        hue         = '0;
        saturation  = '0;
        brightness  = '0;
        rank_length = '0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // all tallies equal after reset
        offer(REQ_RANK,  8'd0,   8'd0,   8'd0,   4'd11);
        offer(REQ_PIXEL, 8'd0,   8'd0,   8'd0,   4'd0);
        offer(REQ_PIXEL, 8'd180, 8'd43,  8'd220, 4'd0);
        offer(REQ_PIXEL, 8'd90,  8'd30,  8'd221, 4'd0);
        offer(REQ_PIXEL, 8'd60,  8'd31,  8'd255, 4'd0);
        offer(REQ_PIXEL, 8'd0,   8'd255, 8'd255, 4'd0);
        offer(REQ_PIXEL, 8'd156, 8'd43,  8'd47,  4'd0);
        offer(REQ_PIXEL, 8'd11,  8'd43,  8'd47,  4'd0);
        offer(REQ_PIXEL, 8'd34,  8'd200, 8'd100, 4'd0);
        offer(REQ_PIXEL, 8'd35,  8'd100, 8'd100, 4'd0);
        offer(REQ_PIXEL, 8'd99,  8'd100, 8'd100, 4'd0);
        offer(REQ_PIXEL, 8'd124, 8'd100, 8'd100, 4'd0);
        offer(REQ_PIXEL, 8'd155, 8'd100, 8'd100, 4'd0);
        // hue past the top of the scale
        offer(REQ_PIXEL, 8'd181, 8'd0,   8'd0,   4'd0);
        offer(REQ_PIXEL, 8'd255, 8'd255, 8'd255, 4'd15);
        offer(REQ_RANK,  8'd0,   8'd0,   8'd0,   4'd0);
        // length above eleven, pixel fields ignored
        offer(REQ_RANK,  8'd255, 8'd255, 8'd255, 4'd15);
        offer(REQ_RANK,  8'd0,   8'd0,   8'd0,   4'd1);
        offer(REQ_PIXEL, 8'd77,  8'd43,  8'd46,  4'd0);
        offer(REQ_PIXEL, 8'd10,  8'd43,  8'd47,  4'd0);
        offer(REQ_PIXEL, 8'd25,  8'd43,  8'd47,  4'd0);
        offer(REQ_RANK,  8'd0,   8'd0,   8'd0,   4'd3);

        for (int i = 0; i < 340; i++) begin
            calm = (i >= 150 && i < 230);
            if (i == 260) begin
                // receiver holds off while ranks pile up behind the stalled output
                hold_req = 1'b1;
                offer(REQ_RANK, 8'd0, 8'd0, 8'd0, 4'd11);
                random_pixel();
                random_rank();
            end
            if ($urandom_range(99) < 14) random_rank();
            else random_pixel();
        end
        in_valid = 1'b0;

        wait (n_owed == 0);
        repeat (150) @(posedge clk);
        if (n_fails == 0 && n_owed == 0) begin
            $display("hsv_color_class_histogram_rank_top: match");
        end else begin
            $display("hsv_color_class_histogram_rank_top: mismatch");
        end
        $finish;
    end

    initial begin
        #(12 * 400000);
        $display("hsv_color_class_histogram_rank_top: mismatch");
        $finish;
    end

endmodule
